// ===== rtl/hsl_pkg.sv =====
// hsl_pkg: shared types and defaults of the hsl to rgb converter
// used by hsl_chan, hsl_to_rgb_converter and the testbench; depends on nothing

package hsl_pkg;

   // fraction bits of every fixed point field (1.0 is 1 << FRAC_BITS)
   localparam int FRAC_BITS_DEFAULT = 16;

   // load enables of the pipeline stages that the channel units hold
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

// ===== rtl/hsl_chan.sv =====
// hsl_chan: one color channel, hue wrap, segment pick, ramp multiply and clamp
// stages 2 to 5 of the converter pipeline; depends on hsl_pkg

module hsl_chan #(
   parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT,
   localparam int W  = FRAC_BITS + 1,
   localparam int TW = W + 2,
   localparam int DW = W + 2,
   localparam int PW = W + 3
) (
   input  logic                 clock,
   input  hsl_pkg::stage_en_type en,
   input  logic signed [TW-1:0] t_raw,
   input  logic [DW-1:0]        d_in,
   input  logic signed [PW-1:0] p_in,
   input  logic [W:0]           q_in,
   output logic [W-1:0]         value
);

   localparam int SW = W + 3;
   localparam int MW = DW + W;
   localparam int RW = MW + 1;
   localparam int CW = W + 6;
   localparam int ONE_I = 1 << FRAC_BITS;

   localparam logic signed [TW-1:0] ONE_T  = TW'(ONE_I);
   localparam logic [SW-1:0]        ONE_S  = SW'(ONE_I);
   localparam logic [SW-1:0]        THREE_S = SW'(3 * ONE_I);
   localparam logic [SW-1:0]        FOUR_S = SW'(4 * ONE_I);
   localparam logic [RW-1:0]        HALF_R = RW'(ONE_I / 2);
   localparam logic signed [CW-1:0] ONE_C  = CW'(ONE_I);
   localparam logic [W-1:0]         ONE_W  = W'(ONE_I);

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_FLAT,
      SEG_FALL,
      SEG_LOW
   } seg_type;

   logic [W-1:0]  tw_ff, tw_in;
   logic [W-1:0]  f_ff, f_in;
   seg_type       seg3_ff, seg3_in;
   logic [MW-1:0] m_ff, m_in;
   seg_type       seg4_ff;
   logic [W-1:0]  value_ff, value_in;

   // stage 2: wrap the point once into 0..1, exactly 1.0 stays
   always_comb begin
      logic signed [TW-1:0] t_adj;
      priority if (t_raw < 0) begin
         t_adj = t_raw + ONE_T;
      end else if (t_raw > ONE_T) begin
         t_adj = t_raw - ONE_T;
      end else begin
         t_adj = t_raw;
      end
      tw_in = t_adj[W-1:0];
   end

   // stage 3: segment and ramp factor from 6t
   always_comb begin
      logic [SW-1:0] six_t;
      logic [SW-1:0] fall_f;
      six_t  = ({3'b000, tw_ff} << 2) + ({3'b000, tw_ff} << 1);
      fall_f = FOUR_S - six_t;
      priority if (six_t < ONE_S) begin
         seg3_in = SEG_RISE;
         f_in    = six_t[W-1:0];
      end else if (six_t < THREE_S) begin
         seg3_in = SEG_FLAT;
         f_in    = '0;
      end else if (six_t < FOUR_S) begin
         seg3_in = SEG_FALL;
         f_in    = fall_f[W-1:0];
      end else begin
         seg3_in = SEG_LOW;
         f_in    = '0;
      end
   end

   // stage 4: (q - p) times the ramp factor
   assign m_in = MW'(d_in) * MW'(f_ff);

   // stage 5: round, add p, select by segment and clamp to 0..1
   always_comb begin
      logic [RW-1:0]        rnd;
      logic signed [CW-1:0] p_ext;
      logic signed [CW-1:0] m_ext;
      logic signed [CW-1:0] pre;
      rnd   = RW'(m_ff) + HALF_R;
      p_ext = CW'(p_in);
      m_ext = $signed(CW'(rnd[RW-1:FRAC_BITS]));
      unique case (seg4_ff)
         SEG_RISE, SEG_FALL: pre = p_ext + m_ext;
         SEG_FLAT:           pre = $signed(CW'(q_in));
         SEG_LOW:            pre = p_ext;
         default:            pre = p_ext;
      endcase
      priority if (pre < 0) begin
         value_in = '0;
      end else if (pre > ONE_C) begin
         value_in = ONE_W;
      end else begin
         value_in = pre[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         tw_ff <= tw_in;
      end
      if (en.s3) begin
         f_ff    <= f_in;
         seg3_ff <= seg3_in;
      end
      if (en.s4) begin
         m_ff    <= m_in;
         seg4_ff <= seg3_ff;
      end
      if (en.s5) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== rtl/hsl_to_rgb_converter.sv =====
// hsl_to_rgb_converter: top level, input saturation, q and p, handshake pipeline
// depends on hsl_pkg and hsl_chan
//
// converts one pixel a word from hue, saturation, luminance to red, green, blue,
// all unsigned fixed point with FRAC_BITS fraction bits (1 << FRAC_BITS is 1.0)
// req_ channel: hsl word in, req_tdata holds hue, saturation, luminance
// rsp_ channel: rgb word out, rsp_tdata holds red, green, blue
// five register stages: saturate inputs; l times (1+s) or s and the hue wrap;
// q, p and the segment of each channel; the three ramp multiplies; round,
// select and clamp into the output register
// throughput: one word per clock while rsp_tready stays high; every stage then takes a new word each clock
// zero saturation needs no special path: q and p both equal luminance
// each stage moves on when it is empty or the stage after it moves, so a
// stalled receiver fills the bubbles first and then holds req_tready low;
// nothing is dropped or repeated
// reset (synchronous) empties the pipeline; payload registers keep old data

module hsl_to_rgb_converter #(
   parameter int FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT,
   localparam int W = FRAC_BITS + 1,
   localparam int DATA_W = ((3 * W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,  // hue, saturation, luminance, zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata   // red, green, blue, zero fill
);

   localparam int TW = W + 2;
   localparam int DW = W + 2;
   localparam int PW = W + 3;
   localparam int BW = W + 1;
   localparam int XW = 2 * W + 1;
   localparam int RW = XW + 1;
   localparam int QW = RW - FRAC_BITS;
   localparam int DS = W + 4;
   localparam int ONE_I = 1 << FRAC_BITS;

   localparam logic [W-1:0]         ONE_W   = W'(ONE_I);
   localparam logic [W-1:0]         HALF_W  = W'(ONE_I / 2);
   localparam logic [BW-1:0]        ONE_B   = BW'(ONE_I);
   localparam logic [RW-1:0]        HALF_R  = RW'(ONE_I / 2);
   localparam logic signed [TW-1:0] THIRD_T = TW'((ONE_I + 1) / 3);

   // handshake of the five stages
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;
   hsl_pkg::stage_en_type chan_en;

   // stage 1
   logic [W-1:0] h1_ff, s1_ff, l1_ff;
   logic [W-1:0] h1_in, s1_in, l1_in;
   // stage 2
   logic [XW-1:0] prod2_ff, prod2_in;
   logic          low2_ff, low2_in;
   logic [W-1:0]  l2_ff, s2_ff;
   // stage 3
   logic [W:0]           q3_ff, q3_in;
   logic signed [PW-1:0] p3_ff, p3_in;
   logic [DW-1:0]        d3_ff, d3_in;
   // stage 4
   logic [W:0]           q4_ff;
   logic signed [PW-1:0] p4_ff;

   logic signed [TW-1:0] t_red, t_green, t_blue;
   logic [W-1:0]         red, green, blue;

   assign en5 = !v5_ff || rsp_tready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   assign chan_en.s2 = en2;
   assign chan_en.s3 = en3;
   assign chan_en.s4 = en4;
   assign chan_en.s5 = en5;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // stage 1: unpack and saturate inputs above one
   always_comb begin
      logic [W-1:0] h_raw, s_raw, l_raw;
      h_raw = req_tdata[W-1:0];
      s_raw = req_tdata[2*W-1:W];
      l_raw = req_tdata[3*W-1:2*W];
      h1_in = (h_raw > ONE_W) ? ONE_W : h_raw;
      s1_in = (s_raw > ONE_W) ? ONE_W : s_raw;
      l1_in = (l_raw > ONE_W) ? ONE_W : l_raw;
   end

   // stage 2: l*(1+s) below half luminance, l*s at or above
   always_comb begin
      logic [BW-1:0] mul_b;
      low2_in  = (l1_ff < HALF_W);
      mul_b    = low2_in ? (ONE_B + BW'(s1_ff)) : BW'(s1_ff);
      prod2_in = XW'(l1_ff) * XW'(mul_b);
   end

   // channel points taken from the registered hue
   always_comb begin
      logic signed [TW-1:0] h_ext;
      h_ext   = $signed(TW'(h1_ff));
      t_red   = h_ext + THIRD_T;
      t_green = h_ext;
      t_blue  = h_ext - THIRD_T;
   end

   // stage 3: round the product, form q, p and the clipped q - p
   always_comb begin
      logic [RW-1:0]        rnd;
      logic [QW-1:0]        prod_r;
      logic [QW-1:0]        q_full;
      logic signed [DS-1:0] d_s;
      rnd    = RW'(prod2_ff) + HALF_R;
      prod_r = rnd[RW-1:FRAC_BITS];
      q_full = low2_ff ? prod_r : (QW'(l2_ff) + QW'(s2_ff) - prod_r);
      q3_in  = q_full[W:0];
      p3_in  = $signed(PW'({l2_ff, 1'b0})) - $signed(PW'(q3_in));
      d_s    = $signed(DS'(q3_in)) - DS'(p3_in);
      d3_in  = (d_s < 0) ? '0 : d_s[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         h1_ff <= h1_in;
         s1_ff <= s1_in;
         l1_ff <= l1_in;
      end
      if (en2) begin
         prod2_ff <= prod2_in;
         low2_ff  <= low2_in;
         l2_ff    <= l1_ff;
         s2_ff    <= s1_ff;
      end
      if (en3) begin
         q3_ff <= q3_in;
         p3_ff <= p3_in;
         d3_ff <= d3_in;
      end
      if (en4) begin
         q4_ff <= q3_ff;
         p4_ff <= p3_ff;
      end
   end

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
      .clock (clock),
      .en    (chan_en),
      .t_raw (t_red),
      .d_in  (d3_ff),
      .p_in  (p4_ff),
      .q_in  (q4_ff),
      .value (red)
   );

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
      .clock (clock),
      .en    (chan_en),
      .t_raw (t_green),
      .d_in  (d3_ff),
      .p_in  (p4_ff),
      .q_in  (q4_ff),
      .value (green)
   );

   hsl_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
      .clock (clock),
      .en    (chan_en),
      .t_raw (t_blue),
      .d_in  (d3_ff),
      .p_in  (p4_ff),
      .q_in  (q4_ff),
      .value (blue)
   );

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = DATA_W'({blue, green, red});

   // an accepted word always lands in the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted word did not enter stage 1");

   // a held stage keeps its q and p while the stage after it is stalled
   a_stage4_holds: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !en4) |=> (v4_ff && $stable(p4_ff) && $stable(q4_ff)))
      else $error("stage 4 changed while stalled");

   // every channel shown is clamped to one
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (red <= ONE_W && green <= ONE_W && blue <= ONE_W))
      else $error("channel above one");

endmodule

// ===== verif/testbench.sv =====
// testbench for hsl_to_rgb_converter: streams hsl pixels through the block and checks
// every rgb word against a fixed point predictor kept here; depends on hsl_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC_BITS = hsl_pkg::FRAC_BITS_DEFAULT;
   localparam int FIELD_W = FRAC_BITS + 1;
   localparam int DATA_W = ((3 * FIELD_W + 7) / 8) * 8;
   localparam int PIX_W = 3 * FIELD_W;
   localparam int FULL_SCALE = 1 << FRAC_BITS;
   localparam longint UNIT = longint'(FULL_SCALE);
   localparam longint HALF_LSB = UNIT / 2;
   localparam longint THIRD_TURN = (UNIT + 1) / 3;
   localparam int FIELD_MAX = (1 << FIELD_W) - 1;
   localparam int STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 60;

   // hue in the lowest bits, as on req_tdata
   typedef struct packed {
      logic [FIELD_W-1:0] luminance;
      logic [FIELD_W-1:0] saturation;
      logic [FIELD_W-1:0] hue;
   } hsl_word_type;

   // red in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [FIELD_W-1:0] blue;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] red;
   } rgb_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // hue, saturation, luminance, zero fill
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // red, green, blue, zero fill

   hsl_to_rgb_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   hsl_word_type pixel_queue[$];
   rgb_word_type rgb_expected[$];
   int words_offered = 0;
   int words_taken = 0;
   int words_checked = 0;
   int gray_words = 0;
   int over_words = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int stall_left = 0;

   // ---------------- predictor ----------------

   function automatic longint clip_unit(logic [FIELD_W-1:0] v);
      return (longint'(v) > UNIT) ? UNIT : longint'(v);
   endfunction

   // product of two nonnegative fractions, rounded to nearest, halves up
   function automatic longint frac_mul(longint a, longint b);
      return (a * b + HALF_LSB) >>> FRAC_BITS;
   endfunction

   function automatic logic [FIELD_W-1:0] clamp_channel(longint v);
      longint c;
      c = (v < 0) ? 0 : ((v > UNIT) ? UNIT : v);
      return c[FIELD_W-1:0];
   endfunction

   function automatic longint ramp_level(longint t, longint p, longint q);
      longint d;
      longint tw;
      d = (q - p < 0) ? 0 : q - p;
      tw = t;
      if (tw < 0) tw = tw + UNIT;
      // exactly one stays and lands in the flat low segment
      if (tw > UNIT) tw = tw - UNIT;
      if (6 * tw < UNIT) return p + frac_mul(d, 6 * tw);
      if (2 * tw < UNIT) return q;
      if (3 * tw < 2 * UNIT) return p + frac_mul(d, 4 * UNIT - 6 * tw);
      return p;
   endfunction

   function automatic rgb_word_type hsl_to_rgb(hsl_word_type w);
      longint h;
      longint s;
      longint l;
      longint q;
      longint p;
      rgb_word_type res;
      h = clip_unit(w.hue);
      s = clip_unit(w.saturation);
      l = clip_unit(w.luminance);
      if (s == 0) begin
         res.red = clamp_channel(l);
         res.green = clamp_channel(l);
         res.blue = clamp_channel(l);
      end else begin
         if (2 * l < UNIT) begin
            q = frac_mul(l, UNIT + s);
         end else begin
            q = l + s - frac_mul(l, s);
         end
         p = 2 * l - q;
         res.red = clamp_channel(ramp_level(h + THIRD_TURN, p, q));
         res.green = clamp_channel(ramp_level(h, p, q));
         res.blue = clamp_channel(ramp_level(h - THIRD_TURN, p, q));
      end
      return res;
   endfunction

   // ---------------- stimulus helpers ----------------

   // segment edges, wrap points and out of range codes
   function automatic logic [FIELD_W-1:0] edge_value(int idx);
      case (idx)
         0:  return 17'd0;
         1:  return 17'd1;
         2:  return FIELD_W'(FULL_SCALE - 1);
         3:  return FIELD_W'(FULL_SCALE);
         4:  return FIELD_W'(FULL_SCALE + 1);
         5:  return 17'd10922;
         6:  return 17'd10923;
         7:  return 17'd21845;
         8:  return 17'd21846;
         9:  return 17'd32767;
         10: return 17'd32768;
         11: return 17'd43690;
         12: return 17'd43691;
         13: return 17'd54613;
         14: return 17'd54614;
         default: return FIELD_W'(FIELD_MAX);
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] random_field();
      int sel;
      sel = $urandom_range(99);
      if (sel < 75) return FIELD_W'($urandom_range(FULL_SCALE));
      if (sel < 88) return edge_value($urandom_range(15));
      return FIELD_W'($urandom_range(FIELD_MAX));
   endfunction

   function automatic hsl_word_type random_pixel();
      hsl_word_type w;
      w.hue = random_field();
      w.saturation = ($urandom_range(9) == 0) ? '0 : random_field();
      w.luminance = random_field();
      return w;
   endfunction

   task automatic queue_pixel(int h, int s, int l);
      hsl_word_type w;
      w.hue = FIELD_W'(h);
      w.saturation = FIELD_W'(s);
      w.luminance = FIELD_W'(l);
      pixel_queue = {pixel_queue, w};
   endtask

   task automatic queue_random(int count);
      hsl_word_type w;
      repeat (count) begin
         w = random_pixel();
         pixel_queue = {pixel_queue, w};
      end
   endtask

   // sender side holds off until every word is back
   task automatic wait_drained();
      while (pixel_queue.size() != 0 || words_taken != words_offered ||
             rgb_expected.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic check_channel(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // ---------------- driver ----------------

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || words_taken == words_offered) begin
         if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata <= {{(DATA_W - PIX_W){1'b0}}, pixel_queue.pop_front()};
            req_tvalid <= 1'b1;
            words_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------- receiver ----------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin : monitor
      hsl_word_type in_word;
      rgb_word_type got;
      rgb_word_type want;
      cycle_count++;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            in_word = req_tdata[PIX_W-1:0];
            rgb_expected = {rgb_expected, hsl_to_rgb(in_word)};
            words_taken++;
            if (in_word.saturation == 0) gray_words++;
            if (in_word.hue > FULL_SCALE || in_word.saturation > FULL_SCALE ||
                in_word.luminance > FULL_SCALE)
               over_words++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[PIX_W-1:0];
            if (rgb_expected.size() == 0) begin
               fail_count++;
               $error("rgb word %0h arrived with none expected", got);
            end else begin
               want = rgb_expected.pop_front();
               check_channel("red", want.red, got.red);
               check_channel("green", want.green, got.green);
               check_channel("blue", want.blue, got.blue);
               words_checked++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench failed");
         $finish;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver mostly stalls
      send_idle_pct = 29;
      recv_idle_pct = 80;
      queue_pixel(0, 0, 0);
      queue_pixel(FULL_SCALE, FULL_SCALE, FULL_SCALE);
      queue_pixel(FIELD_MAX, FIELD_MAX, FIELD_MAX);     // all fields above one
      queue_pixel(0, 0, 32768);                          // gray
      queue_pixel(12345, 0, 40000);                      // gray, hue ignored
      queue_pixel(0, FULL_SCALE, 32768);
      queue_pixel(21845, FULL_SCALE, 32768);
      queue_pixel(43691, FULL_SCALE, 32768);             // red point lands on one
      queue_pixel(FULL_SCALE, FULL_SCALE, 32768);        // green point equals one
      queue_pixel(10922, FULL_SCALE, 32768);
      queue_pixel(10923, FULL_SCALE, 32768);
      queue_pixel(32767, FULL_SCALE, 16000);
      queue_pixel(32768, FULL_SCALE, 16000);
      queue_pixel(43690, FULL_SCALE, 50000);
      queue_pixel(43691, FULL_SCALE, 50000);
      queue_pixel(21844, 30000, 32767);                  // luminance just under half
      queue_pixel(21844, 30000, 32768);                  // luminance at half
      queue_pixel(100, 65535, 1);                        // blue point wraps below zero
      queue_pixel(65000, 1, 65535);                      // red point wraps above one
      queue_pixel(17'h10001, 17'h10000, 17'h15555);
      queue_pixel(17'h0AAAA, 17'h15555, 17'h0AAAA);
      queue_pixel(17'h15555, 17'h0AAAA, 17'h15555);
      queue_random(633);
      wait_drained();

      // swapped: sender mostly idle, receiver lightly
      send_idle_pct = 80;
      recv_idle_pct = 29;
      queue_random(633);
      wait_drained();

      // full rate, with one long receiver stall to back up the pipeline
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      queue_random(634);
      wait_drained();

      repeat (10) @(posedge clock);
      if (rgb_expected.size() != 0) begin
         fail_count++;
         $error("%0d rgb words never arrived", rgb_expected.size());
      end
      $display("converted and checked %0d pixels in three stall patterns", words_checked);
      $display("%0d gray pixels, %0d with a field above one", gray_words, over_words);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
